// File: hw/rtl/isaac_pkg.sv
package isaac_pkg;
  localparam int LOG_WORDS = 8;
  localparam int WORDS = 1 << LOG_WORDS;
  localparam logic [31:0] GOLDEN = 32'h9e3779b9;
  localparam logic [1:0] KIND_SEED = 2'd0;
  localparam logic [1:0] KIND_INIT = 2'd1;
  localparam logic [1:0] KIND_REQ = 2'd2;
  typedef logic [LOG_WORDS-1:0] addr_t;
  typedef logic [31:0] word_t;

  // shift of one scramble-round step on eight words, step 0..7
  function automatic word_t shift_step(input word_t v, input logic [2:0] s);
    word_t r;
    case (s)
      3'd0: r = v << 11;
      3'd1: r = v >> 2;
      3'd2: r = v << 8;
      3'd3: r = v >> 16;
      3'd4: r = v << 10;
      3'd5: r = v >> 4;
      3'd6: r = v << 8;
      default: r = v >> 9;
    endcase
    return r;
  endfunction
endpackage

// File: hw/rtl/isaac_ram.sv
module isaac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hw/rtl/isaac_mixer.sv
// eight-word scramble register file, one step of the round per cycle while step is high
module isaac_mixer
  import isaac_pkg::*;
(
  input  logic       clk,
  input  logic       load_golden,
  input  logic       step,
  input  logic [2:0] step_idx,
  input  logic       add_en,
  input  logic [2:0] add_idx,
  input  word_t      add_val,
  input  logic [2:0] rd_idx,
  output word_t      rd_word
);
  word_t w_r [8];
  logic [2:0] i0, i1, i2, i3;

  assign i0 = step_idx;
  assign i1 = step_idx + 3'd1;
  assign i2 = step_idx + 3'd2;
  assign i3 = step_idx + 3'd3;
  assign rd_word = w_r[rd_idx];

  always_ff @(posedge clk) begin
    if (load_golden) begin
      for (int k = 0; k < 8; k++) begin
        w_r[k] <= GOLDEN;
      end
    end else if (step) begin
      w_r[i0] <= w_r[i0] ^ shift_step(w_r[i1], step_idx);
      w_r[i3] <= w_r[i3] + (w_r[i0] ^ shift_step(w_r[i1], step_idx));
      w_r[i1] <= w_r[i1] + w_r[i2];
    end else if (add_en) begin
      w_r[add_idx] <= w_r[add_idx] + add_val;
    end
  end
endmodule

// File: hw/rtl/isaac32_random_generator.sv
// isaac32_random_generator: 32-bit isaac pseudo-random word source
// input channel: in_valid/in_stall with in_kind, in_seed_index, in_seed_value,
//   in_has_seed. kind 0 writes a seed word into the result store, kind 1
//   initializes (golden words scrambled, one or two pool fill passes, then a
//   regeneration), kind 2 requests one random word, kind 3 is ignored.
// output channel: out_valid/out_stall with out_random_word, only for kind 2.
// one item is handled at a time; in_stall is high while an item is at work
//   or its word waits in the output register.
// timing: seed loads go back to back; a request when words remain reads the
//   result store (S_RRD, then S_OUT) and then presents its word; a request on
//   an empty store first regenerates 256 words with one pool memory read port
//   shared; initialization scrambles and fills the pool, then one regeneration.
// words come out from the highest store index down to the lowest.
// reset clears the control state and the accumulators; pool and result store
//   are not reset: seed loads write the result store, initialization both.
// while a word waits and out_stall is high, the word holds and no new item is taken.
module isaac32_random_generator
  import isaac_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_seed_index,
  input  logic [31:0] in_seed_value,
  input  logic        in_has_seed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_random_word
);
  localparam logic [4:0] S_IDLE = 5'd0, S_SCR = 5'd1, S_FRD = 5'd2,
    S_FWAIT = 5'd3, S_FADD = 5'd4, S_FSCR = 5'd5, S_FWR = 5'd6,
    S_G0 = 5'd7, S_G1 = 5'd8, S_G2 = 5'd9, S_G3 = 5'd10, S_G4 = 5'd11,
    S_RRD = 5'd12, S_RWAIT = 5'd13, S_OUT = 5'd14, S_GSTART = 5'd15;

  logic [4:0] st_r, st_nxt;
  word_t a_r, a_nxt, b_r, b_nxt, cnt_r, cnt_nxt, x_r, x_nxt, y_r, y_nxt;
  word_t out_r, out_nxt;
  logic [8:0] rem_r, rem_nxt;
  logic [LOG_WORDS-1:0] i_r, i_nxt;
  logic [2:0] k_r, k_nxt;
  logic [2:0] sc_r, sc_nxt;
  logic pass_r, pass_nxt, seeded_r, seeded_nxt, after_r, after_nxt, ov_r, ov_nxt;

  logic pw, rw, mg, mstep, madd;
  addr_t pwa, pra, rwa, rra;
  word_t pwd, rwd, pq, rq, mw;

  isaac_ram #(.WIDTH(32), .DEPTH(WORDS)) u_pool (
    .clk(clk), .we(pw), .waddr(pwa), .wdata(pwd), .raddr(pra), .rdata(pq));
  isaac_ram #(.WIDTH(32), .DEPTH(WORDS)) u_res (
    .clk(clk), .we(rw), .waddr(rwa), .wdata(rwd), .raddr(rra), .rdata(rq));
  isaac_mixer u_mix (
    .clk(clk), .load_golden(mg), .step(mstep), .step_idx(k_r), .add_en(madd),
    .add_idx(k_r), .add_val(pass_r ? pq : rq), .rd_idx(k_r), .rd_word(mw));

  assign in_stall = (st_r != S_IDLE) || ov_r;
  assign out_valid = ov_r;
  assign out_random_word = out_r;

  always_comb begin
    st_nxt = st_r; a_nxt = a_r; b_nxt = b_r; cnt_nxt = cnt_r; x_nxt = x_r;
    y_nxt = y_r; out_nxt = out_r; rem_nxt = rem_r; i_nxt = i_r;
    k_nxt = k_r; sc_nxt = sc_r; pass_nxt = pass_r; seeded_nxt = seeded_r;
    after_nxt = after_r; ov_nxt = ov_r && out_stall;
    pw = 1'b0; rw = 1'b0; mg = 1'b0; mstep = 1'b0; madd = 1'b0;
    pwa = i_r; pra = i_r; rwa = i_r; rra = i_r; pwd = mw; rwd = b_r;
    case (st_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          case (in_kind)
            KIND_SEED: begin
              rw = 1'b1; rwa = in_seed_index[LOG_WORDS-1:0]; rwd = in_seed_value;
            end
            KIND_INIT: begin
              mg = 1'b1; a_nxt = '0; b_nxt = '0; cnt_nxt = '0;
              seeded_nxt = in_has_seed; sc_nxt = 3'd0; k_nxt = 3'd0;
              i_nxt = '0; pass_nxt = !in_has_seed; st_nxt = S_SCR;
            end
            KIND_REQ: begin
              if (rem_r == 9'd0) begin
                after_nxt = 1'b1; st_nxt = S_GSTART;
              end else begin
                rem_nxt = rem_r - 9'd1; st_nxt = S_RRD;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCR: begin
        mstep = 1'b1; k_nxt = k_r + 3'd1;
        if (k_r == 3'd7) begin
          sc_nxt = sc_r + 3'd1;
          if (sc_r == 3'd3) begin
            st_nxt = seeded_r ? S_FRD : S_FSCR;
          end
        end
      end
      S_FRD: st_nxt = S_FWAIT;
      S_FWAIT: st_nxt = S_FADD;
      S_FADD: begin
        madd = 1'b1; k_nxt = k_r + 3'd1; i_nxt = i_r + addr_t'(1);
        st_nxt = (k_r == 3'd7) ? S_FSCR : S_FRD;
      end
      S_FSCR: begin
        mstep = 1'b1; k_nxt = k_r + 3'd1;
        if (k_r == 3'd7) begin
          i_nxt = seeded_r ? i_r - addr_t'(8) : i_r; st_nxt = S_FWR;
        end
      end
      S_FWR: begin
        pw = 1'b1; k_nxt = k_r + 3'd1; i_nxt = i_r + addr_t'(1);
        if (k_r == 3'd7) begin
          if (i_r == addr_t'(WORDS - 1)) begin
            if (seeded_r && !pass_r) begin
              pass_nxt = 1'b1; st_nxt = S_FRD;
            end else begin
              after_nxt = 1'b0; st_nxt = S_GSTART;
            end
          end else begin
            st_nxt = seeded_r ? S_FRD : S_FSCR;
          end
        end
      end
      S_GSTART: begin
        cnt_nxt = cnt_r + 32'd1; b_nxt = b_r + cnt_r + 32'd1; i_nxt = '0;
        st_nxt = S_G0;
      end
      S_G0: begin
        pra = i_r; st_nxt = S_G1;
        case (i_r[1:0])
          2'd0: a_nxt = a_r ^ (a_r << 13);
          2'd1: a_nxt = a_r ^ (a_r >> 6);
          2'd2: a_nxt = a_r ^ (a_r << 2);
          default: a_nxt = a_r ^ (a_r >> 16);
        endcase
      end
      S_G1: begin
        pra = i_r + addr_t'(WORDS / 2); x_nxt = pq; st_nxt = S_G2;
      end
      S_G2: begin
        pra = x_r[LOG_WORDS+1:2]; a_nxt = a_r + pq; st_nxt = S_G3;
      end
      S_G3: begin
        y_nxt = pq + a_r + b_r; pw = 1'b1; pwa = i_r; pwd = pq + a_r + b_r;
        st_nxt = S_G4;
      end
      S_G4: begin
        pra = y_r[2*LOG_WORDS+1:LOG_WORDS+2]; st_nxt = S_RWAIT;
      end
      S_RWAIT: begin
        b_nxt = pq + x_r; rw = 1'b1; rwd = pq + x_r; i_nxt = i_r + addr_t'(1);
        st_nxt = S_G0;
        if (i_r == addr_t'(WORDS - 1)) begin
          if (after_r) begin
            rem_nxt = 9'(WORDS - 1); st_nxt = S_RRD;
          end else begin
            rem_nxt = 9'(WORDS); st_nxt = S_IDLE;
          end
        end
      end
      S_RRD: begin
        rra = rem_r[LOG_WORDS-1:0]; st_nxt = S_OUT;
      end
      S_OUT: begin
        out_nxt = rq; ov_nxt = 1'b1; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
    if (st_r == S_FRD || st_r == S_FWAIT || st_r == S_FADD) begin
      pra = i_r; rra = i_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; a_r <= '0; b_r <= '0; cnt_r <= '0; rem_r <= '0;
      ov_r <= 1'b0; i_r <= '0; k_r <= '0; sc_r <= '0; pass_r <= 1'b0;
      seeded_r <= 1'b0; after_r <= 1'b0;
    end else begin
      st_r <= st_nxt; a_r <= a_nxt; b_r <= b_nxt; cnt_r <= cnt_nxt;
      rem_r <= rem_nxt; ov_r <= ov_nxt; i_r <= i_nxt; k_r <= k_nxt;
      sc_r <= sc_nxt; pass_r <= pass_nxt; seeded_r <= seeded_nxt;
      after_r <= after_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt; out_r <= out_nxt;
  end
endmodule

// File: tb/sv/tb_isaac32_random_generator.sv
`timescale 1ns / 100ps

module tb_isaac32_random_generator;
  import isaac_pkg::*;

  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam int WDOG_LIMIT = 50000;
  localparam int TAIL_ITEMS = 80;
  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  idx;
    logic [31:0] value;
    logic        has_seed;
    bit          wait_drain;
  } item_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_kind;
  logic [7:0]  in_seed_index;
  logic [31:0] in_seed_value;
  logic        in_has_seed;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_random_word;

  isaac32_random_generator dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_seed_index(in_seed_index), .in_seed_value(in_seed_value),
    .in_has_seed(in_has_seed),
    .out_valid(out_valid), .out_stall(out_stall), .out_random_word(out_random_word)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  item_t pending[$];
  word_t words_due[$];
  int    errors = 0;
  int    words_seen = 0;
  int    quiet_cycles = 0;

  // generator state mirror
  word_t pool_m[WORDS];
  word_t store_m[WORDS];
  word_t mix[8];
  word_t acc_a, acc_b, rounds;
  int unsigned words_left;

  function automatic void scramble_mix();
    mix[0] ^= mix[1] << 11; mix[3] += mix[0]; mix[1] += mix[2];
    mix[1] ^= mix[2] >> 2;  mix[4] += mix[1]; mix[2] += mix[3];
    mix[2] ^= mix[3] << 8;  mix[5] += mix[2]; mix[3] += mix[4];
    mix[3] ^= mix[4] >> 16; mix[6] += mix[3]; mix[4] += mix[5];
    mix[4] ^= mix[5] << 10; mix[7] += mix[4]; mix[5] += mix[6];
    mix[5] ^= mix[6] >> 4;  mix[0] += mix[5]; mix[6] += mix[7];
    mix[6] ^= mix[7] << 8;  mix[1] += mix[6]; mix[7] += mix[0];
    mix[7] ^= mix[0] >> 9;  mix[2] += mix[7]; mix[0] += mix[1];
  endfunction

  function automatic void regen_words();
    word_t a, b, x, y, t;
    a = acc_a;
    rounds += 1;
    b = acc_b + rounds;
    for (int i = 0; i < WORDS; i++) begin
      x = pool_m[i];
      case (i % 4)
        0: t = a << 13;
        1: t = a >> 6;
        2: t = a << 2;
        default: t = a >> 16;
      endcase
      a = (a ^ t) + pool_m[(i + WORDS / 2) % WORDS];
      y = pool_m[(x >> 2) % WORDS] + a + b;
      pool_m[i] = y;
      b = pool_m[(y >> (LOG_WORDS + 2)) % WORDS] + x;
      store_m[i] = b;
    end
    acc_a = a;
    acc_b = b;
  endfunction

  function automatic void fill_pool(bit from_store);
    for (int i = 0; i < WORDS; i += 8) begin
      for (int k = 0; k < 8; k++)
        mix[k] += from_store ? store_m[i + k] : pool_m[i + k];
      scramble_mix();
      for (int k = 0; k < 8; k++) pool_m[i + k] = mix[k];
    end
  endfunction

  function automatic void seed_generator(bit seeded);
    acc_a = '0;
    acc_b = '0;
    rounds = '0;
    for (int k = 0; k < 8; k++) mix[k] = GOLDEN;
    for (int k = 0; k < 4; k++) scramble_mix();
    if (seeded) begin
      fill_pool(1'b1);
      fill_pool(1'b0);
    end else begin
      for (int i = 0; i < WORDS; i += 8) begin
        scramble_mix();
        for (int k = 0; k < 8; k++) pool_m[i + k] = mix[k];
      end
    end
    regen_words();
    words_left = WORDS;
  endfunction

  function automatic void predict_word(item_t it);
    case (it.kind)
      KIND_SEED: store_m[it.idx % WORDS] = it.value;
      KIND_INIT: seed_generator(it.has_seed);
      KIND_REQ: begin
        if (words_left == 0) begin
          regen_words();
          words_left = WORDS - 1;
        end else begin
          words_left -= 1;
        end
        words_due.push_back(store_m[words_left % WORDS]);
      end
      default: ;
    endcase
  endfunction

  // driver
  int  send_idle = 0;
  bit  tail;
  assign tail = pending.size() < TAIL_ITEMS;

  always @(posedge clk) begin
    item_t it;
    bit    take;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_kind <= KIND_NONE;
      in_seed_index <= '0;
      in_seed_value <= '0;
      in_has_seed <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        it.kind = in_kind;
        it.idx = in_seed_index;
        it.value = in_seed_value;
        it.has_seed = in_has_seed;
        predict_word(it);
      end
      take = 1'b0;
      if (send_idle > 0) begin
        send_idle--;
      end else if (pending.size() > 0) begin
        if (pending[0].wait_drain && words_due.size() > 0) begin
          take = 1'b0;
        end else if (!tail && $urandom_range(0, 5) == 0) begin
          send_idle = $urandom_range(0, 3);
        end else begin
          take = 1'b1;
        end
      end
      if (take) begin
        it = pending.pop_front();
        in_kind <= it.kind;
        in_seed_index <= it.idx;
        in_seed_value <= it.value;
        in_has_seed <= it.has_seed;
      end
      in_valid <= take;
    end
  end

  // monitor
  int recv_idle = 0;
  int hold_left = 0;
  bit held = 1'b0;

  always @(posedge clk) begin
    word_t want;
    bit    stall_next;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        words_seen++;
        if (words_due.size() == 0) begin
          $error("random_word: no item expected, actual %h", out_random_word);
          errors++;
        end else begin
          want = words_due.pop_front();
          if (out_random_word !== want) begin
            $error("random_word: expected %h, actual %h", want, out_random_word);
            errors++;
          end
        end
      end
      stall_next = 1'b0;
      if (!held && words_seen >= 200) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (recv_idle > 0) begin
        recv_idle--;
        stall_next = 1'b1;
      end else if (!tail && $urandom_range(0, 5) == 0) begin
        recv_idle = $urandom_range(0, 3);
        stall_next = 1'b1;
      end
      out_stall <= stall_next;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_LIMIT) begin
      $display("isaac32_random_generator test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic item_t mk(logic [1:0] k, logic [7:0] i, logic [31:0] v, logic h,
                               bit d = 1'b0);
    item_t it;
    it.kind = k;
    it.idx = i;
    it.value = v;
    it.has_seed = h;
    it.wait_drain = d;
    return it;
  endfunction

  initial begin
    int r;
    rst_n = 1'b0;
    // directed
    pending.push_back(mk(KIND_INIT, 8'd0, 32'd0, 1'b0));
    pending.push_back(mk(KIND_REQ, 8'($urandom), $urandom, 1'($urandom)));
    pending.push_back(mk(KIND_NONE, 8'hff, 32'hffffffff, 1'b1));
    pending.push_back(mk(KIND_REQ, 8'd0, 32'd0, 1'b0));
    pending.push_back(mk(KIND_SEED, 8'd0, 32'd0, 1'b0));
    pending.push_back(mk(KIND_SEED, 8'hff, 32'hffffffff, 1'b1));
    pending.push_back(mk(KIND_SEED, 8'h55, 32'haaaaaaaa, 1'b0));
    pending.push_back(mk(KIND_SEED, 8'haa, 32'h55555555, 1'b1));
    pending.push_back(mk(KIND_INIT, 8'hff, 32'hffffffff, 1'b1));
    pending.push_back(mk(KIND_REQ, 8'hff, 32'hffffffff, 1'b1));
    pending.push_back(mk(KIND_SEED, 8'hfe, 32'h12345678, 1'b0));
    pending.push_back(mk(KIND_REQ, 8'd0, 32'd0, 1'b0));
    pending.push_back(mk(KIND_REQ, 8'd0, 32'd0, 1'b0, 1'b1));
    pending.push_back(mk(KIND_INIT, 8'd0, 32'd0, 1'b0));
    for (int i = 0; i < 6; i++)
      pending.push_back(mk(KIND_REQ, 8'($urandom), $urandom, 1'($urandom)));
    // random
    for (int i = 0; i < 930; i++) begin
      r = $urandom_range(0, 99);
      if (i > 850)
        pending.push_back(mk(KIND_REQ, 8'($urandom), $urandom, 1'($urandom)));
      else if (r < 18)
        pending.push_back(mk(KIND_SEED, 8'($urandom), $urandom, 1'($urandom)));
      else if (r < 20)
        pending.push_back(mk(KIND_INIT, 8'($urandom), $urandom, 1'($urandom)));
      else if (r < 24)
        pending.push_back(mk(KIND_NONE, 8'($urandom), $urandom, 1'($urandom)));
      else
        pending.push_back(mk(KIND_REQ, 8'($urandom), $urandom, 1'($urandom), r == 99));
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    while (pending.size() > 0 || in_valid) @(posedge clk);
    while (words_due.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && words_due.size() == 0) begin
      $display("isaac32_random_generator test passed");
    end else begin
      $display("isaac32_random_generator test failed");
    end
    $finish;
  end

endmodule
